@@ design/ssps_pkg.sv @@
// ----------------------------------------------------------------------------
// ssps_pkg
// shared constants and functions for the serial sensor poll sequencer
// ----------------------------------------------------------------------------
package ssps_pkg;

    localparam int REPLY_DEPTH  = 64;
    localparam int NUMBER_CHARS = 23;
    localparam int ADDR_W       = $clog2(REPLY_DEPTH);
    localparam int LEN_W        = $clog2(REPLY_DEPTH + 1);

    localparam logic [7:0]  PROMPT_CHAR = 8'h3E;
    localparam logic [7:0]  CR_CHAR     = 8'h0D;
    localparam logic [31:0] BACKOFF_MS  = 32'd200;
    localparam logic [23:0] MAG_CAP     = 24'd9000000;
    localparam logic [23:0] CO2_MAX     = 24'd8388607;
    localparam logic [23:0] CO2_NEG_MAG = 24'd8388608;

    localparam logic [3:0] PH_IDLE = 4'd8;
    localparam logic [3:0] PH_WAIT = 4'd9;

    localparam logic [1:0] REG_POLL    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_RETRY   = 2'd2;

    // command text, index by command and character
    function automatic logic [5:0] cmd_len(input logic [2:0] c);
        case (c)
            3'd0:    cmd_len = 6'd1;
            3'd1:    cmd_len = 6'd10;
            3'd2:    cmd_len = 6'd8;
            3'd3:    cmd_len = 6'd23;
            default: cmd_len = 6'd4;
        endcase
    endfunction

    function automatic logic [7:0] cmd_char(input logic [2:0] c, input logic [4:0] i);
        string s;
        case (c)
            3'd0:    s = "S";
            3'd1:    s = "SMODE STOP";
            3'd2:    s = "ECHO OFF";
            3'd3:    s = "FORM CO2 \" \" \"ppm\" #r#n";
            default: s = "SEND";
        endcase
        cmd_char = s.getc(int'(i));
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        is_num = (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2B || c == 8'h2E;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

endpackage

@@ design/ssps_ram.sv @@
// ----------------------------------------------------------------------------
// ssps_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module ssps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ design/serial_sensor_poll_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// serial_sensor_poll_sequencer_top
// command sequencer and reply parser for a text-command serial gas sensor
// ----------------------------------------------------------------------------
// An item is a millisecond tick or a received byte. A tick in a send phase
// gives one result per command character plus a closing CR, one per cycle
// through a one-entry output register while the output is not stalled. A
// prompt after a SEND reply starts a parse that walks the 64-byte reply ram
// one address at a time: a forward ppm search, a backward run search and a
// forward number read.
module serial_sensor_poll_sequencer_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [7:0]          s_rx_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_result_kind,
    output logic [7:0]          m_tx_byte,
    output logic signed [23:0]  m_co2_tenths,
    output logic                m_last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import ssps_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECIDE, ST_SEND, ST_FIND_RD, ST_FIND, ST_BACK_RD, ST_BACK,
        ST_RUN_RD, ST_RUN, ST_NUM_RD, ST_NUM, ST_FINISH
    } state_t;

    state_t state_reg;
    logic [15:0] poll_reg, tmo_reg;
    logic [7:0]  lim_reg, retry_reg;
    logic [3:0]  phase_reg;
    logic [31:0] now_reg, sent_reg, next_reg;
    logic [LEN_W-1:0] len_reg;
    logic        op_reg;
    logic [7:0]  byte_reg;
    logic [2:0]  cmd_reg;
    logic [5:0]  ci_reg;
    logic [LEN_W-1:0] pos_reg, search_end_reg, start_reg, stop_reg;
    logic [7:0]  w0_reg, w1_reg;
    logic [23:0] mag_reg;
    logic        neg_reg, frac_reg, signdone_reg;
    logic [1:0]  fd_reg;
    logic [3:0]  rd_reg;
    logic        ov_reg, ok_reg;
    logic        m_valid_reg, m_kind_reg, m_last_reg;
    logic [7:0]  m_tx_reg;
    logic [23:0] m_co2_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_q;

    ssps_ram #(.WIDTH(8), .DEPTH(REPLY_DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(byte_reg), .rdata(ram_q)
    );

    logic waiting;
    logic [7:0] lim_eff;
    logic [31:0] dnow, dnext;
    assign waiting = phase_reg <= PH_WAIT && phase_reg[0];
    assign lim_eff = (lim_reg == 8'd0) ? 8'd1 : lim_reg;
    assign dnow    = now_reg - sent_reg;
    assign dnext   = now_reg - next_reg;

    logic [LEN_W-1:0] pos_dec, start_dec;
    assign pos_dec   = pos_reg - LEN_W'(1);
    assign start_dec = start_reg - LEN_W'(1);

    assign ram_we  = (state_reg == ST_DECIDE) && op_reg && waiting &&
                     byte_reg != PROMPT_CHAR && len_reg < LEN_W'(REPLY_DEPTH);
    assign ram_addr = ram_we                     ? len_reg[ADDR_W-1:0]   :
                      (state_reg == ST_BACK_RD) ? pos_dec[ADDR_W-1:0]   :
                      (state_reg == ST_RUN_RD)  ? start_dec[ADDR_W-1:0] :
                                                  pos_reg[ADDR_W-1:0];

    assign s_ready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_tx_byte     = m_tx_reg;
    assign m_co2_tenths  = m_co2_reg;
    assign m_last        = m_last_reg;

    logic out_load;
    assign out_load = (!m_valid_reg || m_ready) &&
                      (state_reg == ST_SEND || (state_reg == ST_FINISH && ok_reg));

    // mag*10 + d*10 with cap
    logic [27:0] mag_mul;
    logic [3:0]  dig;
    assign dig     = ram_q[3:0];
    assign mag_mul = {4'd0, mag_reg} * 28'd10 + 28'(dig) * 28'd10;

    // rounding and saturation of the reading
    logic [23:0] mag_rnd, mag_sat;
    assign mag_rnd = mag_reg + 24'(rd_reg >= 4'd5);
    assign mag_sat = neg_reg ? ((mag_rnd > CO2_NEG_MAG) ? CO2_NEG_MAG : mag_rnd)
                             : ((mag_rnd > CO2_MAX) ? CO2_MAX : mag_rnd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            poll_reg    <= 16'd10000;
            tmo_reg     <= 16'd1000;
            lim_reg     <= 8'd3;
            retry_reg   <= '0;
            phase_reg   <= '0;
            now_reg     <= '0;
            sent_reg    <= '0;
            next_reg    <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_POLL:    poll_reg <= cfg_data;
                    REG_TIMEOUT: tmo_reg  <= cfg_data;
                    REG_RETRY:   lim_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg    <= s_operation;
                        byte_reg  <= s_rx_byte;
                        state_reg <= ST_DECIDE;
                        if (!s_operation) begin
                            now_reg <= now_reg + 32'd1;
                        end
                    end
                end
                ST_DECIDE: begin
                    state_reg <= ST_IDLE;
                    if (op_reg) begin
                        if (waiting) begin
                            if (byte_reg == PROMPT_CHAR) begin
                                if (phase_reg == PH_WAIT) begin
                                    pos_reg        <= '0;
                                    search_end_reg <= len_reg;
                                    state_reg      <= ST_FIND_RD;
                                end else begin
                                    retry_reg <= '0;
                                    phase_reg <= phase_reg + 4'd1;
                                    if (phase_reg + 4'd1 == PH_IDLE) begin
                                        next_reg <= now_reg;
                                    end
                                    len_reg <= '0;
                                end
                            end else if (len_reg < LEN_W'(REPLY_DEPTH)) begin
                                len_reg <= len_reg + LEN_W'(1);
                            end
                        end
                    end else if (phase_reg < PH_IDLE && !phase_reg[0]) begin
                        cmd_reg   <= phase_reg[3:1];
                        ci_reg    <= '0;
                        len_reg   <= '0;
                        sent_reg  <= now_reg;
                        phase_reg <= phase_reg + 4'd1;
                        state_reg <= ST_SEND;
                    end else if (phase_reg == PH_IDLE) begin
                        if (!dnext[31]) begin
                            cmd_reg   <= 3'd4;
                            ci_reg    <= '0;
                            len_reg   <= '0;
                            sent_reg  <= now_reg;
                            phase_reg <= PH_WAIT;
                            state_reg <= ST_SEND;
                        end
                    end else if (waiting && dnow >= {16'd0, tmo_reg}) begin
                        if (phase_reg == 4'd1) begin
                            retry_reg <= '0;
                            phase_reg <= 4'd2;
                            len_reg   <= '0;
                        end else if (retry_reg + 8'd1 < lim_eff) begin
                            retry_reg <= retry_reg + 8'd1;
                            phase_reg <= (phase_reg == PH_WAIT) ? PH_IDLE : phase_reg - 4'd1;
                            next_reg  <= now_reg + BACKOFF_MS;
                            len_reg   <= '0;
                        end else begin
                            retry_reg <= '0;
                            if (phase_reg == PH_WAIT) begin
                                phase_reg <= PH_IDLE;
                                next_reg  <= now_reg + {16'd0, poll_reg};
                                len_reg   <= '0;
                            end else begin
                                phase_reg <= phase_reg + 4'd1;
                                if (phase_reg + 4'd1 == PH_IDLE) begin
                                    next_reg <= now_reg;
                                end
                            end
                        end
                    end
                end
                ST_SEND: begin
                    if (!m_valid_reg || m_ready) begin
                        m_kind_reg  <= 1'b0;
                        m_co2_reg   <= '0;
                        if (ci_reg == cmd_len(cmd_reg)) begin
                            m_tx_reg   <= CR_CHAR;
                            m_last_reg <= 1'b1;
                            state_reg  <= ST_IDLE;
                        end else begin
                            m_tx_reg   <= cmd_char(cmd_reg, ci_reg[4:0]);
                            m_last_reg <= 1'b0;
                            ci_reg     <= ci_reg + 6'd1;
                        end
                    end
                end
                ST_FIND_RD: begin
                    if (len_reg < LEN_W'(3)) begin
                        pos_reg   <= search_end_reg;
                        state_reg <= ST_BACK_RD;
                    end else begin
                        state_reg <= ST_FIND;
                    end
                end
                ST_FIND: begin
                    // sliding window of last two bytes
                    w0_reg <= w1_reg;
                    w1_reg <= to_lower(ram_q);
                    if (pos_reg >= LEN_W'(2) && w0_reg == 8'h70 && w1_reg == 8'h70 &&
                        to_lower(ram_q) == 8'h6D) begin
                        search_end_reg <= pos_reg - LEN_W'(2);
                        pos_reg        <= pos_reg - LEN_W'(2);
                        state_reg      <= ST_BACK_RD;
                    end else if (pos_reg + LEN_W'(1) >= len_reg) begin
                        pos_reg   <= search_end_reg;
                        state_reg <= ST_BACK_RD;
                    end else begin
                        pos_reg   <= pos_reg + LEN_W'(1);
                        state_reg <= ST_FIND_RD;
                    end
                end
                ST_BACK_RD: begin
                    if (pos_reg == '0) begin
                        ok_reg    <= 1'b0;
                        state_reg <= ST_FINISH;
                    end else begin
                        pos_reg   <= pos_dec;
                        state_reg <= ST_BACK;
                    end
                end
                ST_BACK: begin
                    if (is_num(ram_q)) begin
                        stop_reg  <= pos_reg + LEN_W'(1);
                        start_reg <= pos_reg;
                        state_reg <= ST_RUN_RD;
                    end else begin
                        state_reg <= ST_BACK_RD;
                    end
                end
                ST_RUN_RD: begin
                    if (start_reg == '0) begin
                        state_reg <= ST_NUM_RD;
                    end else begin
                        pos_reg   <= start_dec;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (is_num(ram_q)) begin
                        start_reg <= pos_reg;
                        state_reg <= ST_RUN_RD;
                    end else begin
                        state_reg <= ST_NUM_RD;
                    end
                end
                ST_NUM_RD: begin
                    if (stop_reg - start_reg > LEN_W'(NUMBER_CHARS)) begin
                        stop_reg <= start_reg + LEN_W'(NUMBER_CHARS);
                    end
                    pos_reg      <= start_reg;
                    mag_reg      <= '0;
                    neg_reg      <= 1'b0;
                    frac_reg     <= 1'b0;
                    fd_reg       <= '0;
                    rd_reg       <= '0;
                    signdone_reg <= 1'b0;
                    ov_reg       <= 1'b0;
                    state_reg    <= ST_NUM;
                end
                ST_NUM: begin
                    // ram_q is valid the cycle after pos is set; use ov_reg as read phase
                    if (!ov_reg) begin
                        ov_reg <= 1'b1;
                        if (pos_reg >= stop_reg) begin
                            ok_reg    <= 1'b1;
                            state_reg <= ST_FINISH;
                        end
                    end else begin
                        ov_reg       <= 1'b0;
                        signdone_reg <= 1'b1;
                        pos_reg      <= pos_reg + LEN_W'(1);
                        if (!signdone_reg && (ram_q == 8'h2B || ram_q == 8'h2D)) begin
                            neg_reg <= ram_q == 8'h2D;
                        end else if (ram_q == 8'h2E && !frac_reg) begin
                            frac_reg <= 1'b1;
                        end else if (ram_q < 8'h30 || ram_q > 8'h39) begin
                            ok_reg    <= 1'b1;
                            state_reg <= ST_FINISH;
                        end else if (!frac_reg) begin
                            mag_reg <= (mag_mul > 28'(MAG_CAP)) ? MAG_CAP : mag_mul[23:0];
                        end else begin
                            if (fd_reg == 2'd0) begin
                                mag_reg <= mag_reg + 24'(dig);
                            end else if (fd_reg == 2'd1) begin
                                rd_reg <= dig;
                            end
                            if (fd_reg < 2'd2) begin
                                fd_reg <= fd_reg + 2'd1;
                            end
                        end
                    end
                end
                ST_FINISH: begin
                    if (ok_reg) begin
                        if (!m_valid_reg || m_ready) begin
                            m_kind_reg  <= 1'b1;
                            m_tx_reg    <= '0;
                            m_last_reg  <= 1'b1;
                            m_co2_reg   <= neg_reg ? -mag_sat : mag_sat;
                            phase_reg   <= PH_IDLE;
                            next_reg    <= now_reg + {16'd0, poll_reg};
                            retry_reg   <= '0;
                            len_reg     <= '0;
                            state_reg   <= ST_IDLE;
                        end
                    end else begin
                        state_reg <= ST_IDLE;
                        if (retry_reg + 8'd1 < lim_eff) begin
                            retry_reg <= retry_reg + 8'd1;
                            next_reg  <= now_reg + BACKOFF_MS;
                        end else begin
                            retry_reg <= '0;
                            next_reg  <= now_reg + {16'd0, poll_reg};
                        end
                        phase_reg <= PH_IDLE;
                        len_reg   <= '0;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ tb/serial_sensor_poll_sequencer_top_test.sv @@
// ----------------------------------------------------------------------------
// serial_sensor_poll_sequencer_top_test
// self-checking bench for the serial sensor poll sequencer: a directed table
// walks the command order, prompt handling, parse extremes, a full reply
// buffer and timeouts, then random replies, noise and ticks run under several
// register settings, all but the last with random stalls on both channels
// ----------------------------------------------------------------------------
module serial_sensor_poll_sequencer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssps_pkg::*;

    localparam bit OP_TICK = 1'b0;
    localparam bit OP_BYTE = 1'b1;
    localparam bit KIND_TX = 1'b0;
    localparam bit KIND_READING = 1'b1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 600;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tx;
        logic signed [23:0] co2;
        logic               last;
    } sensor_result_t;

    typedef struct {
        bit    is_tick;
        int    ticks;
        string text;
        bit    has_reading;
        int    reading;
    } step_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_operation;
    logic [7:0]          s_rx_byte;
    logic                m_valid;
    logic                m_ready;
    logic                m_result_kind;
    logic [7:0]          m_tx_byte;
    logic signed [23:0]  m_co2_tenths;
    logic                m_last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [15:0]         cfg_data;

    serial_sensor_poll_sequencer_top uut (.*);

    // sequencer state mirror
    logic [3:0]  phase_m;
    logic [7:0]  retries_m;
    logic [31:0] now_m;
    logic [31:0] sent_at_m;
    logic [31:0] next_at_m;
    logic [7:0]  reply_m [REPLY_DEPTH];
    int          reply_len_m;
    logic [15:0] poll_ms;
    logic [15:0] tmo_ms;
    logic [7:0]  retry_lim;

    sensor_result_t pending_results [$];
    int  errors;
    bit  idle_on;
    int  quiet_cycles;
    int  items;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic string cmd_string(int c);
        case (c)
            0: return "S";
            1: return "SMODE STOP";
            2: return "ECHO OFF";
            3: return "FORM CO2 \" \" \"ppm\" #r#n";
            default: return "SEND";
        endcase
    endfunction

    function automatic bit num_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || c == "-" || c == "+" || c == ".";
    endfunction

    function automatic logic [7:0] lc(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic void push_tx(logic [7:0] b);
        sensor_result_t r;
        r = '{kind: KIND_TX, tx: b, co2: '0, last: 1'b0};
        pending_results.push_back(r);
    endfunction

    function automatic void issue_command(int c, logic [3:0] wait_ph);
        string s;
        s = cmd_string(c);
        reply_len_m = 0;
        for (int i = 0; i < s.len(); i++) push_tx(s[i]);
        push_tx(CR_CHAR);
        sent_at_m = now_m;
        phase_m = wait_ph;
    endfunction

    function automatic bit parse_tenths(output logic signed [23:0] val);
        int num_end, endp, start, stop, pos, fd;
        logic [31:0] mag;
        bit neg, in_frac, found;
        int rd;
        logic [7:0] c;
        num_end = reply_len_m; mag = 0; fd = 0; neg = 0; in_frac = 0;
        found = 0; rd = 0; endp = 0;
        for (int i = 0; i + 2 < reply_len_m; i++) begin
            if (lc(reply_m[i]) == "p" && lc(reply_m[i+1]) == "p" &&
                lc(reply_m[i+2]) == "m") begin
                num_end = i;
                break;
            end
        end
        for (int i = num_end; i > 0; i--) begin
            if (num_char(reply_m[i-1])) begin
                endp = i - 1;
                found = 1;
                break;
            end
        end
        if (!found) return 0;
        start = endp;
        while (start > 0 && num_char(reply_m[start-1])) start--;
        stop = endp + 1;
        if (stop - start > NUMBER_CHARS) stop = start + NUMBER_CHARS;
        pos = start;
        if (reply_m[pos] == "+" || reply_m[pos] == "-") begin
            neg = reply_m[pos] == "-";
            pos++;
        end
        for (; pos < stop; pos++) begin
            c = reply_m[pos];
            if (c == "." && !in_frac) begin
                in_frac = 1;
                continue;
            end
            if (c < "0" || c > "9") break;
            if (!in_frac) begin
                mag = mag * 10 + (c - "0") * 10;
                if (mag > 9000000) mag = 9000000;
            end else begin
                if (fd == 0) mag += c - "0";
                else if (fd == 1) rd = c - "0";
                if (fd < 2) fd++;
            end
        end
        if (rd >= 5) mag++;
        if (neg) begin
            if (mag > 8388608) mag = 8388608;
            val = -$signed(mag[23:0]);
            if (mag == 8388608) val = 24'sh800000;
        end else begin
            if (mag > 8388607) mag = 8388607;
            val = mag[23:0];
        end
        return 1;
    endfunction

    function automatic void retry_or_abandon();
        logic [7:0] lim;
        lim = (retry_lim == 0) ? 8'd1 : retry_lim;
        if ({1'b0, retries_m} + 9'd1 < {1'b0, lim}) begin
            retries_m++;
            phase_m = (phase_m == PH_WAIT) ? PH_IDLE : phase_m - 4'd1;
            next_at_m = now_m + BACKOFF_MS;
            reply_len_m = 0;
            return;
        end
        retries_m = 0;
        if (phase_m == PH_WAIT) begin
            phase_m = PH_IDLE;
            next_at_m = now_m + {16'd0, poll_ms};
            reply_len_m = 0;
        end else begin
            phase_m++;
            if (phase_m == PH_IDLE) next_at_m = now_m;
        end
    endfunction

    function automatic void on_prompt();
        logic signed [23:0] v;
        sensor_result_t r;
        if (phase_m == PH_WAIT) begin
            if (parse_tenths(v)) begin
                r = '{kind: KIND_READING, tx: 8'd0, co2: v, last: 1'b0};
                pending_results.push_back(r);
                phase_m = PH_IDLE;
                next_at_m = now_m + {16'd0, poll_ms};
                retries_m = 0;
                reply_len_m = 0;
            end else begin
                retry_or_abandon();
            end
            return;
        end
        retries_m = 0;
        phase_m++;
        if (phase_m == PH_IDLE) next_at_m = now_m;
        reply_len_m = 0;
    endfunction

    function automatic bit in_wait();
        return phase_m <= PH_WAIT && phase_m[0];
    endfunction

    function automatic void predict_sequencer(bit op, logic [7:0] b);
        int n0;
        logic [31:0] d;
        n0 = pending_results.size();
        if (op == OP_BYTE) begin
            if (in_wait()) begin
                if (b == PROMPT_CHAR) on_prompt();
                else if (reply_len_m < REPLY_DEPTH) begin
                    reply_m[reply_len_m] = b;
                    reply_len_m++;
                end
            end
        end else begin
            now_m++;
            if (phase_m < PH_IDLE && !phase_m[0]) begin
                issue_command(phase_m >> 1, phase_m + 4'd1);
            end else if (phase_m == PH_IDLE) begin
                d = now_m - next_at_m;
                if (!d[31]) issue_command(4, PH_WAIT);
            end else if (in_wait()) begin
                if (now_m - sent_at_m >= {16'd0, tmo_ms}) begin
                    if (phase_m == 4'd1) begin
                        retries_m = 0;
                        phase_m = 4'd2;
                        reply_len_m = 0;
                    end else begin
                        retry_or_abandon();
                    end
                end
            end
        end
        if (pending_results.size() > n0)
            pending_results[pending_results.size()-1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // sender
    task automatic put_item(bit op, logic [7:0] b, bit has_reading = 0, int reading = 0);
        int n0;
        sensor_result_t r;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        n0 = pending_results.size();
        predict_sequencer(op, b);
        if (has_reading) begin
            while (pending_results.size() > n0) void'(pending_results.pop_back());
            r = '{kind: KIND_READING, tx: 8'd0, co2: 24'(reading), last: 1'b1};
            pending_results.push_back(r);
        end
        items++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_POLL:    poll_ms = data;
            REG_TIMEOUT: tmo_ms = data;
            REG_RETRY:   retry_lim = data[7:0];
            default: ;
        endcase
    endtask

    task automatic send_text(string s, bit has_reading = 0, int reading = 0);
        for (int i = 0; i < s.len(); i++)
            put_item(OP_BYTE, s[i], has_reading && i == s.len() - 1, reading);
    endtask

    task automatic send_reply();
        logic [7:0] q [$];
        string unit;
        int k;
        k = $urandom_range(0, 9);
        repeat ($urandom_range(0, 3)) q.push_back(" ");
        if (k == 0) begin
            repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 3))
                0: q.push_back("-");
                1: q.push_back("+");
                default: ;
            endcase
            repeat ($urandom_range(k == 1 ? 8 : 1, k == 1 ? 26 : 5))
                q.push_back(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 3) != 0) begin
                q.push_back(".");
                repeat ($urandom_range(0, 3)) q.push_back(8'("0" + $urandom_range(0, 9)));
            end
            if (k == 2) q.push_back("-");
            unit = $urandom_range(0, 1) ? " ppm" : " PpM";
            if (k != 3) for (int i = 0; i < unit.len(); i++) q.push_back(unit[i]);
            if (k == 4) repeat (60) q.push_back("x");
            q.push_back(8'h0D);
            q.push_back(8'h0A);
        end
        foreach (q[i]) put_item(OP_BYTE, q[i] == PROMPT_CHAR ? 8'h3F : q[i]);
        put_item(OP_BYTE, PROMPT_CHAR);
    endtask

    task automatic random_run(int n);
        int stop_at;
        stop_at = items + n;
        while (items < stop_at) begin
            if (in_wait()) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: send_reply();
                    6: put_item(OP_BYTE, 8'($urandom_range(0, 255)));
                    default: repeat ($urandom_range(1, 20))
                        put_item(OP_TICK, 8'($urandom_range(0, 255)));
                endcase
            end else begin
                if ($urandom_range(0, 7) == 0) put_item(OP_BYTE, 8'($urandom_range(0, 255)));
                else repeat ($urandom_range(1, 4)) put_item(OP_TICK, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // receiver
    initial begin
        int stall;
        stall = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                stall = $urandom_range(1, 15) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result check and watchdog
    always @(posedge aclk) begin
        sensor_result_t w;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", 32'(m_tx_byte), 32'd0);
            end else begin
                w = pending_results.pop_front();
                if (m_result_kind !== w.kind)
                    report_mismatch("kind", 32'(m_result_kind), 32'(w.kind));
                if (m_tx_byte !== w.tx) report_mismatch("tx_byte", 32'(m_tx_byte), 32'(w.tx));
                if (m_co2_tenths !== w.co2)
                    report_mismatch("co2_tenths", 32'(m_co2_tenths), 32'(w.co2));
                if (m_last !== w.last) report_mismatch("last", 32'(m_last), 32'(w.last));
            end
        end
    end

    initial begin
        step_row_t rows [$];
        string fill;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = 1'b0;
        s_rx_byte = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = REG_POLL;
        cfg_data = 16'd0;
        errors = 0;
        idle_on = 1'b1;
        quiet_cycles = 0;
        items = 0;
        phase_m = 4'd0; retries_m = 0; now_m = 0; sent_at_m = 0; next_at_m = 0;
        reply_len_m = 0;
        poll_ms = 16'd10000; tmo_ms = 16'd1000; retry_lim = 8'd3;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_POLL, 16'd0);
        write_reg(REG_TIMEOUT, 16'd20);
        write_reg(REG_RETRY, 16'd1);

        fill = "";
        repeat (66) fill = {fill, "a"};
        rows = '{
            '{1, 1, "", 0, 0},
            '{0, 0, "x>", 0, 0},
            '{0, 0, "A", 0, 0},
            '{1, 1, "", 0, 0}, '{0, 0, ">", 0, 0},
            '{1, 1, "", 0, 0}, '{0, 0, ">", 0, 0},
            '{1, 1, "", 0, 0}, '{0, 0, ">", 0, 0},
            '{1, 1, "", 0, 0},
            '{0, 0, " 12.35 ppm\r\n>", 1, 124},
            '{1, 1, "", 0, 0},
            '{0, 0, "-8388608.96PPM>", 1, -8388608},
            '{1, 1, "", 0, 0},
            '{0, 0, "99999999.9 ppm>", 1, 8388607},
            '{1, 1, "", 0, 0},
            '{0, 0, "no number>", 0, 0},
            '{1, 1, "", 0, 0},
            '{0, 0, "ppm 5>", 0, 0},
            '{1, 1, "", 0, 0},
            '{0, 0, {fill, "7>"}, 0, 0},
            '{1, 25, "", 0, 0},
            '{1, 1, "", 0, 0},
            '{0, 0, "1.2.3 ppm>", 0, 0}
        };
        foreach (rows[i]) begin
            if (rows[i].is_tick) repeat (rows[i].ticks) put_item(OP_TICK, 8'hFF);
            else send_text(rows[i].text, rows[i].has_reading, rows[i].reading);
        end

        write_reg(REG_POLL, 16'd7);
        write_reg(REG_TIMEOUT, 16'd30);
        write_reg(REG_RETRY, 16'd3);
        random_run(45);

        write_reg(REG_POLL, 16'd65535);
        write_reg(REG_TIMEOUT, 16'd65535);
        write_reg(REG_RETRY, 16'd255);
        random_run(15);

        write_reg(REG_POLL, 16'd3);
        write_reg(REG_TIMEOUT, 16'd0);
        write_reg(REG_RETRY, 16'd0);
        random_run(15);
        drain_results();
        random_run(15);

        write_reg(REG_POLL, 16'd2);
        write_reg(REG_TIMEOUT, 16'd25);
        write_reg(REG_RETRY, 16'd2);
        idle_on = 1'b0;
        random_run(25);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
